[sv/ray_triangle_intersect_assert.svh]
// ----------------------------------------------------------------------------
// Ray/triangle intersect assertion macros
// Concurrent property wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef RAY_TRIANGLE_INTERSECT_ASSERT_SVH
`define RAY_TRIANGLE_INTERSECT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define RTI_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ray_triangle_intersect: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define RTI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ray_triangle_intersect: next-cycle check failed");

`else

`define RTI_ASSERT_IMPLY(label, ante, cons)
`define RTI_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[sv/rti_pkg.sv]
// ----------------------------------------------------------------------------
// Ray/triangle intersect package
// Fixed-point formats, derived widths and arithmetic types of the tester.
// ----------------------------------------------------------------------------
package rti_pkg;

    localparam int COORD_BITS  = 16;
    localparam int FRAC_BITS   = 8;
    localparam int PACK_W      = 48;
    localparam int LIMIT_BITS  = 16;

    localparam int EXT_W   = (3 * COORD_BITS > PACK_W) ? 3 * COORD_BITS : PACK_W;
    localparam int EDGE_W  = COORD_BITS + 1;
    localparam int CROSS_W = 2 * EDGE_W + 1;
    localparam int PROD_W  = EDGE_W + CROSS_W;
    localparam int DOT_W   = PROD_W + 2;
    localparam int NEG_W   = DOT_W + 1;
    localparam int SUM_W   = NEG_W + 1;
    localparam int CMP_W   = NEG_W + LIMIT_BITS + FRAC_BITS;

    localparam int STAGES  = 7;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [EDGE_W-1:0]     edge_t;
    typedef logic signed [CROSS_W-1:0]    cross_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [DOT_W-1:0]      dot_t;
    typedef logic signed [NEG_W-1:0]      neg_t;
    typedef logic signed [SUM_W-1:0]      sum_t;
    typedef logic signed [CMP_W-1:0]      cmp_t;
    typedef logic        [LIMIT_BITS-1:0] limit_t;
    typedef logic        [EXT_W-1:0]      ext_t;

endpackage

[sv/ray_triangle_intersect.sv]
// ----------------------------------------------------------------------------
// Ray/triangle intersect
// Pipelined from input transfer to result, one register per stage.
// Throughput: one triangle/ray pair per cycle; a stall at the output fills
// bubbles first and holds the input only when every stage is occupied.
// Reset: asynchronous, active low; clears all stage valid bits, data is kept.
// Exact Moller-Trumbore hit test in signed fixed point, no division.
// ----------------------------------------------------------------------------
`include "ray_triangle_intersect_assert.svh"

module ray_triangle_intersect
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [47:0] vertex_a,
    input  logic [47:0] vertex_b,
    input  logic [47:0] vertex_c,
    input  logic [47:0] ray_origin,
    input  logic [47:0] ray_direction,
    input  logic [15:0] ray_limit,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        hit
);

    logic [rti_pkg::STAGES-1:0] v_reg;
    logic [rti_pkg::STAGES-1:0] v_next;
    logic [rti_pkg::STAGES-1:0] en;

    // stage 0: edges
    rti_pkg::ext_t   ext_a, ext_b, ext_c, ext_o, ext_d;
    rti_pkg::coord_t ca [3];
    rti_pkg::coord_t cb [3];
    rti_pkg::coord_t cc [3];
    rti_pkg::coord_t co [3];
    rti_pkg::coord_t cd [3];
    rti_pkg::edge_t  e1_next [3];
    rti_pkg::edge_t  e2_next [3];
    rti_pkg::edge_t  tv_next [3];
    rti_pkg::edge_t  dir_next [3];
    rti_pkg::edge_t  e1_reg [3];
    rti_pkg::edge_t  e2_reg [3];
    rti_pkg::edge_t  tv_reg [3];
    rti_pkg::edge_t  dir_reg [3];
    rti_pkg::limit_t lim0_reg;

    // stage 1: cross products
    rti_pkg::cross_t p_next [3];
    rti_pkg::cross_t q_next [3];
    rti_pkg::cross_t p_reg [3];
    rti_pkg::cross_t q_reg [3];
    rti_pkg::edge_t  e1b_reg [3];
    rti_pkg::edge_t  e2b_reg [3];
    rti_pkg::edge_t  tvb_reg [3];
    rti_pkg::edge_t  dirb_reg [3];
    rti_pkg::limit_t lim1_reg;

    // stage 2: dot product terms (det, u, v, t)
    rti_pkg::prod_t  prod_next [4][3];
    rti_pkg::prod_t  prod_reg [4][3];
    rti_pkg::limit_t lim2_reg;

    // stage 3: dot sums
    rti_pkg::dot_t   dot_next [4];
    rti_pkg::dot_t   dot_reg [4];
    rti_pkg::limit_t lim3_reg;

    // stage 4: sign fold
    rti_pkg::neg_t   adet_next, fun_next, fvn_next, ftn_next;
    rti_pkg::neg_t   adet_reg, fun_reg, fvn_reg, ftn_reg;
    logic            zero4_next, zero4_reg;
    rti_pkg::limit_t lim4_reg;

    // stage 5: limit scaling and barycentric checks
    rti_pkg::cmp_t   ldet_next, tns_next;
    rti_pkg::cmp_t   ldet_reg, tns_reg;
    logic            miss_uv_next, miss_uv_reg;
    logic            tneg_next, tneg_reg;
    logic            zero5_reg;
    rti_pkg::sum_t   uv_sum;

    // stage 6: result
    logic            hit_next, hit_reg;

    // ------------------------------------------------------------------------
    // flow control
    // ------------------------------------------------------------------------
    always_comb
    begin
        en[rti_pkg::STAGES-1] = !v_reg[rti_pkg::STAGES-1] || !out_stall;
        for (int k = rti_pkg::STAGES - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
        v_next = v_reg;
        if (en[0])
        begin
            v_next[0] = in_valid;
        end
        for (int k = 1; k < rti_pkg::STAGES; k++)
        begin
            if (en[k])
            begin
                v_next[k] = v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign in_stall  = !en[0];
    assign out_valid = v_reg[rti_pkg::STAGES-1];
    assign hit       = hit_reg;

    // ------------------------------------------------------------------------
    // stage 0: unpack and form E1, E2, T
    // ------------------------------------------------------------------------
    always_comb
    begin
        ext_a = rti_pkg::ext_t'(vertex_a);
        ext_b = rti_pkg::ext_t'(vertex_b);
        ext_c = rti_pkg::ext_t'(vertex_c);
        ext_o = rti_pkg::ext_t'(ray_origin);
        ext_d = rti_pkg::ext_t'(ray_direction);
        for (int i = 0; i < 3; i++)
        begin
            ca[i] = rti_pkg::coord_t'(ext_a[i*rti_pkg::COORD_BITS +: rti_pkg::COORD_BITS]);
            cb[i] = rti_pkg::coord_t'(ext_b[i*rti_pkg::COORD_BITS +: rti_pkg::COORD_BITS]);
            cc[i] = rti_pkg::coord_t'(ext_c[i*rti_pkg::COORD_BITS +: rti_pkg::COORD_BITS]);
            co[i] = rti_pkg::coord_t'(ext_o[i*rti_pkg::COORD_BITS +: rti_pkg::COORD_BITS]);
            cd[i] = rti_pkg::coord_t'(ext_d[i*rti_pkg::COORD_BITS +: rti_pkg::COORD_BITS]);
            e1_next[i]  = rti_pkg::edge_t'(cb[i]) - rti_pkg::edge_t'(ca[i]);
            e2_next[i]  = rti_pkg::edge_t'(cc[i]) - rti_pkg::edge_t'(ca[i]);
            tv_next[i]  = rti_pkg::edge_t'(co[i]) - rti_pkg::edge_t'(ca[i]);
            dir_next[i] = rti_pkg::edge_t'(cd[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            e1_reg   <= e1_next;
            e2_reg   <= e2_next;
            tv_reg   <= tv_next;
            dir_reg  <= dir_next;
            lim0_reg <= ray_limit;
        end
    end

    // ------------------------------------------------------------------------
    // stage 1: P = D x E2, Q = T x E1
    // ------------------------------------------------------------------------
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            p_next[i] = rti_pkg::cross_t'(dir_reg[(i+1)%3]) * rti_pkg::cross_t'(e2_reg[(i+2)%3])
                      - rti_pkg::cross_t'(dir_reg[(i+2)%3]) * rti_pkg::cross_t'(e2_reg[(i+1)%3]);
            q_next[i] = rti_pkg::cross_t'(tv_reg[(i+1)%3]) * rti_pkg::cross_t'(e1_reg[(i+2)%3])
                      - rti_pkg::cross_t'(tv_reg[(i+2)%3]) * rti_pkg::cross_t'(e1_reg[(i+1)%3]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            p_reg    <= p_next;
            q_reg    <= q_next;
            e1b_reg  <= e1_reg;
            e2b_reg  <= e2_reg;
            tvb_reg  <= tv_reg;
            dirb_reg <= dir_reg;
            lim1_reg <= lim0_reg;
        end
    end

    // ------------------------------------------------------------------------
    // stage 2: dot product terms
    // ------------------------------------------------------------------------
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod_next[0][i] = rti_pkg::prod_t'(e1b_reg[i])  * rti_pkg::prod_t'(p_reg[i]);
            prod_next[1][i] = rti_pkg::prod_t'(tvb_reg[i])  * rti_pkg::prod_t'(p_reg[i]);
            prod_next[2][i] = rti_pkg::prod_t'(dirb_reg[i]) * rti_pkg::prod_t'(q_reg[i]);
            prod_next[3][i] = rti_pkg::prod_t'(e2b_reg[i])  * rti_pkg::prod_t'(q_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            prod_reg <= prod_next;
            lim2_reg <= lim1_reg;
        end
    end

    // ------------------------------------------------------------------------
    // stage 3: dot sums
    // ------------------------------------------------------------------------
    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            dot_next[j] = rti_pkg::dot_t'(prod_reg[j][0]) + rti_pkg::dot_t'(prod_reg[j][1])
                        + rti_pkg::dot_t'(prod_reg[j][2]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            dot_reg  <= dot_next;
            lim3_reg <= lim2_reg;
        end
    end

    // ------------------------------------------------------------------------
    // stage 4: fold the sign of det into all numerators
    // ------------------------------------------------------------------------
    always_comb
    begin
        zero4_next = (dot_reg[0] == '0);
        if (dot_reg[0] < 0)
        begin
            adet_next = -rti_pkg::neg_t'(dot_reg[0]);
            fun_next  = -rti_pkg::neg_t'(dot_reg[1]);
            fvn_next  = -rti_pkg::neg_t'(dot_reg[2]);
            ftn_next  = -rti_pkg::neg_t'(dot_reg[3]);
        end
        else
        begin
            adet_next = rti_pkg::neg_t'(dot_reg[0]);
            fun_next  = rti_pkg::neg_t'(dot_reg[1]);
            fvn_next  = rti_pkg::neg_t'(dot_reg[2]);
            ftn_next  = rti_pkg::neg_t'(dot_reg[3]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            adet_reg  <= adet_next;
            fun_reg   <= fun_next;
            fvn_reg   <= fvn_next;
            ftn_reg   <= ftn_next;
            zero4_reg <= zero4_next;
            lim4_reg  <= lim3_reg;
        end
    end

    // ------------------------------------------------------------------------
    // stage 5: scale limit by det, check u and v
    // ------------------------------------------------------------------------
    always_comb
    begin
        ldet_next    = rti_pkg::cmp_t'(adet_reg) * rti_pkg::cmp_t'(lim4_reg);
        tns_next     = rti_pkg::cmp_t'(ftn_reg) <<< rti_pkg::FRAC_BITS;
        uv_sum       = rti_pkg::sum_t'(fun_reg) + rti_pkg::sum_t'(fvn_reg);
        miss_uv_next = (fun_reg < 0) || (fun_reg > adet_reg) || (fvn_reg < 0)
                     || (uv_sum > rti_pkg::sum_t'(adet_reg));
        tneg_next    = (ftn_reg < 0);
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            ldet_reg    <= ldet_next;
            tns_reg     <= tns_next;
            miss_uv_reg <= miss_uv_next;
            tneg_reg    <= tneg_next;
            zero5_reg   <= zero4_reg;
        end
    end

    // ------------------------------------------------------------------------
    // stage 6: result
    // ------------------------------------------------------------------------
    assign hit_next = !zero5_reg && !miss_uv_reg && !tneg_reg && !(tns_reg > ldet_reg);

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            hit_reg <= hit_next;
        end
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    `RTI_ASSERT_IMPLY(a_stall_only_when_full, in_stall, (&v_reg) && out_stall)
    `RTI_ASSERT_NEXT(a_parallel_is_miss, v_reg[5] && en[6] && zero5_reg, out_valid && !hit_reg)
    `RTI_ASSERT_NEXT(a_outside_is_miss, v_reg[5] && en[6] && miss_uv_reg, out_valid && !hit_reg)

endmodule
